@@ rtl/shss_pkg.sv @@
`default_nettype none
package shss_pkg;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_HOME   = 2'd1;
	localparam logic [1:0] OP_GOTO   = 2'd2;
	localparam logic [1:0] OP_DEFINE = 2'd3;

	localparam logic [1:0] MS_NOT_READY = 2'd0;
	localparam logic [1:0] MS_HOMING    = 2'd1;
	localparam logic [1:0] MS_MOVING    = 2'd2;
	localparam logic [1:0] MS_AT_TARGET = 2'd3;

	localparam logic [1:0] HS_SEEK    = 2'd0;
	localparam logic [1:0] HS_RETRACT = 2'd1;
	localparam logic [1:0] HS_REFINE  = 2'd2;

	localparam logic signed [31:0] HOME_PRESET   = 32'sd4000;
	localparam logic signed [31:0] RETRACT_POS   = 32'sd40;
	localparam logic signed [31:0] REFINE_POS    = -32'sd10;
	localparam logic [15:0]        SEEK_SPEED    = 16'd60;
	localparam logic [15:0]        RETRACT_SPEED = 16'd40;
	localparam logic [15:0]        REFINE_SPEED  = 16'd20;
	localparam logic [15:0]        PARK_SPEED    = 16'd50;

	typedef enum logic [3:0] {
		MODE_NOT_READY = 4'b0001,
		MODE_HOMING    = 4'b0010,
		MODE_MOVING    = 4'b0100,
		MODE_AT_TARGET = 4'b1000
	} mode_t;

	typedef enum logic [2:0] {
		STG_SEEK    = 3'b001,
		STG_RETRACT = 3'b010,
		STG_REFINE  = 3'b100
	} stage_t;

	typedef struct packed {
		logic [1:0]         machine_state;
		logic [1:0]         homing_stage;
		logic               stop_motor;
		logic               load_position_valid;
		logic signed [31:0] load_position_value;
		logic               target_valid;
		logic signed [31:0] target_position;
		logic [15:0]        max_speed;
		logic               homed_event;
		logic               reached_event;
		logic [3:0]         station_out;
		logic               error;
	} result_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		case (m)
			MODE_HOMING:    c = MS_HOMING;
			MODE_MOVING:    c = MS_MOVING;
			MODE_AT_TARGET: c = MS_AT_TARGET;
			default:        c = MS_NOT_READY;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] stage_code(input stage_t s);
		logic [1:0] c;
		case (s)
			STG_RETRACT: c = HS_RETRACT;
			STG_REFINE:  c = HS_REFINE;
			default:     c = HS_SEEK;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/shss_station_ram.sv @@
`default_nettype none
module shss_station_ram #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic signed [31:0]            rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic signed [31:0]       wr_data
);
	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;
	logic signed [31:0] fwd_data_q;
	logic               fwd_q;

	// write lands at the same edge as the read, so forward it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

@@ rtl/stepper_homing_station_sequencer.sv @@
// Stepper homing and station sequencer.
// Input channel (in_valid / in_stall): one op per transfer (tick, start homing,
// go to station, define station) with the home switch level and the position
// the driver reports. Output channel (out_valid / out_stall): exactly one result
// per input transfer, in order, carrying the driver commands and events.
// park_position is written through cfg_wr_en / cfg_wr_data while idle; this is
// the user's duty, not enforced by the block. Throughput: one item per cycle
// unless the receiver stalls. Inputs are registered into stage 1, results into
// res_q. The station table read is issued at the input transfer and completes
// in stage 1, where the read-modify-write of the sequencer state happens; a
// define followed by a go-to of the same station is forwarded around the table.
// Reset: not ready, seeking stage, one station (park), nothing in flight. The
// table itself is not cleared; entries are always defined before use.
// When the receiver stalls, the result holds and stage 1 can still take one
// more item; after that in_stall rises until the result is taken.
`default_nettype none
module stepper_homing_station_sequencer #(
	parameter int STATION_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic signed [31:0] cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic [3:0]         station_index,
	input  wire logic signed [31:0] station_address,
	input  wire logic [15:0]        speed,
	input  wire logic               home_switch,
	input  wire logic signed [31:0] current_position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              machine_state,
	output logic [1:0]              homing_stage,
	output logic                    stop_motor,
	output logic                    load_position_valid,
	output logic signed [31:0]      load_position_value,
	output logic                    target_valid,
	output logic signed [31:0]      target_position,
	output logic [15:0]             max_speed,
	output logic                    homed_event,
	output logic                    reached_event,
	output logic [3:0]              station_out,
	output logic                    error
);
	import shss_pkg::*;

	localparam int AW = $clog2(STATION_DEPTH);
	localparam int CW = $clog2(STATION_DEPTH + 1);

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [3:0]         idx_s1;
	logic signed [31:0] saddr_s1;
	logic [15:0]        spd_s1;
	logic               sw_s1;
	logic signed [31:0] pos_s1;
	logic signed [31:0] tbl_rd_s1;

	mode_t              mode_q, mode_n;
	stage_t             stage_q, stage_n;
	logic [CW-1:0]      count_q, count_n;
	logic [3:0]         act_station_q, act_station_n;
	logic signed [31:0] act_addr_q, act_addr_n;
	logic signed [31:0] park_q;

	logic               out_valid_q;
	result_t            res_q, res;

	logic               adv, acc;
	logic               wr_en;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;

	shss_station_ram #(
		.DEPTH(STATION_DEPTH)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (AW'(station_index)),
		.rd_data (tbl_rd_s1),
		.wr_en   (wr_en),
		.wr_addr (AW'(count_q)),
		.wr_data (saddr_s1)
	);

	always_comb begin
		logic signed [31:0] pos;
		logic               full;
		logic               in_range;
		pos           = pos_s1;
		full          = count_q >= CW'(STATION_DEPTH);
		in_range      = 9'(idx_s1) < 9'(count_q);
		mode_n        = mode_q;
		stage_n       = stage_q;
		count_n       = count_q;
		act_station_n = act_station_q;
		act_addr_n    = act_addr_q;
		wr_en         = 1'b0;
		res           = '0;
		case (op_s1)
			OP_HOME: begin
				mode_n                  = MODE_HOMING;
				stage_n                 = STG_SEEK;
				res.stop_motor          = 1'b1;
				res.load_position_valid = 1'b1;
				res.load_position_value = HOME_PRESET;
				res.target_valid        = 1'b1;
				res.max_speed           = SEEK_SPEED;
			end
			OP_GOTO: begin
				if (!in_range) begin
					res.error = 1'b1;
				end else begin
					act_station_n       = idx_s1;
					act_addr_n          = (idx_s1 == 4'd0) ? park_q : tbl_rd_s1;
					mode_n              = MODE_MOVING;
					res.target_valid    = 1'b1;
					res.target_position = act_addr_n;
					res.max_speed       = spd_s1;
					res.station_out     = idx_s1;
				end
			end
			OP_DEFINE: begin
				if (full) begin
					res.error = 1'b1;
				end else begin
					wr_en           = valid_s1 && adv;
					res.station_out = 4'(count_q);
					count_n         = count_q + CW'(1);
				end
			end
			default: begin
				if (mode_q == MODE_HOMING) begin
					if (stage_n == STG_SEEK && sw_s1) begin
						res.stop_motor          = 1'b1;
						res.load_position_valid = 1'b1;
						res.load_position_value = '0;
						pos                     = '0;
						res.target_valid        = 1'b1;
						res.target_position     = RETRACT_POS;
						res.max_speed           = RETRACT_SPEED;
						stage_n                 = STG_RETRACT;
					end
					if (stage_n == STG_RETRACT && pos >= RETRACT_POS) begin
						res.target_valid    = 1'b1;
						res.target_position = REFINE_POS;
						res.max_speed       = REFINE_SPEED;
						stage_n             = STG_REFINE;
					end
					if (stage_n == STG_REFINE && sw_s1) begin
						res.stop_motor          = 1'b1;
						res.load_position_valid = 1'b1;
						res.load_position_value = '0;
						act_station_n           = 4'd0;
						act_addr_n              = park_q;
						mode_n                  = MODE_MOVING;
						res.target_valid        = 1'b1;
						res.target_position     = park_q;
						res.max_speed           = PARK_SPEED;
						res.station_out         = 4'd0;
						res.homed_event         = 1'b1;
					end
				end else if (mode_q == MODE_MOVING) begin
					if (pos_s1 == act_addr_q) begin
						mode_n            = MODE_AT_TARGET;
						res.reached_event = 1'b1;
						res.station_out   = act_station_q;
					end
				end
			end
		endcase
		res.machine_state = mode_code(mode_n);
		res.homing_stage  = stage_code(stage_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			mode_q        <= MODE_NOT_READY;
			stage_q       <= STG_SEEK;
			count_q       <= CW'(1);
			act_station_q <= '0;
			act_addr_q    <= '0;
			park_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				park_q <= cfg_wr_data;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q   <= 1'b1;
				mode_q        <= mode_n;
				stage_q       <= stage_n;
				count_q       <= count_n;
				act_station_q <= act_station_n;
				act_addr_q    <= act_addr_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1    <= op;
			idx_s1   <= station_index;
			saddr_s1 <= station_address;
			spd_s1   <= speed;
			sw_s1    <= home_switch;
			pos_s1   <= current_position;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid           = out_valid_q;
	assign machine_state       = res_q.machine_state;
	assign homing_stage        = res_q.homing_stage;
	assign stop_motor          = res_q.stop_motor;
	assign load_position_valid = res_q.load_position_valid;
	assign load_position_value = res_q.load_position_value;
	assign target_valid        = res_q.target_valid;
	assign target_position     = res_q.target_position;
	assign max_speed           = res_q.max_speed;
	assign homed_event         = res_q.homed_event;
	assign reached_event       = res_q.reached_event;
	assign station_out         = res_q.station_out;
	assign error               = res_q.error;

endmodule
`default_nettype wire

@@ rtl/shss_checker.sv @@
`default_nettype none
module shss_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [1:0]         machine_state,
	input wire logic               stop_motor,
	input wire logic               load_position_valid,
	input wire logic               target_valid,
	input wire logic signed [31:0] target_position,
	input wire logic [15:0]        max_speed,
	input wire logic               homed_event,
	input wire logic               reached_event,
	input wire logic [3:0]         station_out,
	input wire logic               error
);
	import shss_pkg::*;

	// stalled result stays valid with machine_state and station_out held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(machine_state) && $stable(station_out))
		else $error("result changed while stalled");

	a_homed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && homed_event |-> machine_state == MS_MOVING && target_valid
			&& load_position_valid && stop_motor && station_out == 4'd0
			&& max_speed == PARK_SPEED)
		else $error("homed transfer without park command");

	a_reached: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reached_event |-> machine_state == MS_AT_TARGET && !target_valid
			&& !homed_event)
		else $error("reached transfer inconsistent");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !target_valid && !load_position_valid && !stop_motor
			&& !homed_event && !reached_event)
		else $error("error transfer issued a command");

	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !target_valid |-> target_position == 32'sd0 && max_speed == 16'd0)
		else $error("target fields set without target");

endmodule

bind stepper_homing_station_sequencer shss_checker u_shss_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_stall           (out_stall),
	.machine_state       (machine_state),
	.stop_motor          (stop_motor),
	.load_position_valid (load_position_valid),
	.target_valid        (target_valid),
	.target_position     (target_position),
	.max_speed           (max_speed),
	.homed_event         (homed_event),
	.reached_event       (reached_event),
	.station_out         (station_out),
	.error               (error)
);
`default_nettype wire

@@ tb/tb_stepper_homing_station_sequencer.sv @@
`timescale 1ns / 1ps
module tb_stepper_homing_station_sequencer;
	import shss_pkg::*;

	localparam int DEPTH = 16;

	typedef struct {
		logic [1:0]         op;
		logic [3:0]         station_index;
		logic signed [31:0] station_address;
		logic [15:0]        speed;
		logic               home_switch;
		logic signed [31:0] current_position;
	} seq_cmd_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic signed [31:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic [3:0]         station_index;
	logic signed [31:0] station_address;
	logic [15:0]        speed;
	logic               home_switch;
	logic signed [31:0] current_position;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         machine_state;
	logic [1:0]         homing_stage;
	logic               stop_motor;
	logic               load_position_valid;
	logic signed [31:0] load_position_value;
	logic               target_valid;
	logic signed [31:0] target_position;
	logic [15:0]        max_speed;
	logic               homed_event;
	logic               reached_event;
	logic [3:0]         station_out;
	logic               error;

	stepper_homing_station_sequencer #(.STATION_DEPTH(DEPTH)) dut (.*);

	// sequencer shadow state
	logic [1:0]         seq_mode;
	logic [1:0]         seq_stage;
	logic signed [31:0] seq_table [DEPTH];
	int                 seq_count;
	logic [3:0]         seq_station;
	logic signed [31:0] seq_dest;
	logic signed [31:0] seq_park;

	seq_cmd_t pending_cmds[$];
	result_t  expected_results[$];
	int       mismatches;
	int       queued_items;
	bit       in_taken;
	int       burst_left;
	int       gap_left;
	int       gap_max;
	int       stall_pct;
	int       hold_left;
	bit       hold_request;

	// stimulus-side view of the station table
	logic signed [31:0] gen_addr [DEPTH];
	int                 gen_count;
	logic signed [31:0] gen_park;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb_stepper_homing_station_sequencer: FAIL");
		$finish;
	end

	function automatic result_t sequencer_step(input seq_cmd_t c);
		result_t            r;
		logic signed [31:0] pos;
		r = '0;
		pos = c.current_position;
		case (c.op)
			OP_HOME: begin
				seq_mode = MS_HOMING;
				seq_stage = HS_SEEK;
				r.stop_motor = 1'b1;
				r.load_position_valid = 1'b1;
				r.load_position_value = HOME_PRESET;
				r.target_valid = 1'b1;
				r.target_position = '0;
				r.max_speed = SEEK_SPEED;
			end
			OP_GOTO: begin
				if (int'(c.station_index) >= seq_count) begin
					r.error = 1'b1;
				end else begin
					seq_station = c.station_index;
					seq_dest = (c.station_index == 4'd0) ? seq_park : seq_table[c.station_index];
					seq_mode = MS_MOVING;
					r.target_valid = 1'b1;
					r.target_position = seq_dest;
					r.max_speed = c.speed;
					r.station_out = c.station_index;
				end
			end
			OP_DEFINE: begin
				if (seq_count >= DEPTH) begin
					r.error = 1'b1;
				end else begin
					seq_table[seq_count] = c.station_address;
					r.station_out = 4'(seq_count);
					seq_count++;
				end
			end
			OP_TICK: begin
				if (seq_mode == MS_HOMING) begin
					if (seq_stage == HS_SEEK && c.home_switch) begin
						r.stop_motor = 1'b1;
						r.load_position_valid = 1'b1;
						r.load_position_value = '0;
						pos = '0;
						r.target_valid = 1'b1;
						r.target_position = RETRACT_POS;
						r.max_speed = RETRACT_SPEED;
						seq_stage = HS_RETRACT;
					end
					if (seq_stage == HS_RETRACT && pos >= RETRACT_POS) begin
						r.target_valid = 1'b1;
						r.target_position = REFINE_POS;
						r.max_speed = REFINE_SPEED;
						seq_stage = HS_REFINE;
					end
					if (seq_stage == HS_REFINE && c.home_switch) begin
						r.stop_motor = 1'b1;
						r.load_position_valid = 1'b1;
						r.load_position_value = '0;
						seq_station = '0;
						seq_dest = seq_park;
						seq_mode = MS_MOVING;
						r.target_valid = 1'b1;
						r.target_position = seq_park;
						r.max_speed = PARK_SPEED;
						r.station_out = '0;
						r.homed_event = 1'b1;
					end
				end else if (seq_mode == MS_MOVING && pos == seq_dest) begin
					seq_mode = MS_AT_TARGET;
					r.reached_event = 1'b1;
					r.station_out = seq_station;
				end
			end
		endcase
		r.machine_state = seq_mode;
		r.homing_stage = seq_stage;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic seq_cmd_t rand_cmd(input logic [1:0] code);
		seq_cmd_t c;
		c.op = code;
		c.station_index = 4'($urandom);
		c.station_address = $urandom;
		c.speed = 16'($urandom);
		c.home_switch = 1'($urandom);
		c.current_position = $urandom;
		return c;
	endfunction

	function automatic seq_cmd_t tick_cmd(input logic sw, input logic signed [31:0] pos);
		seq_cmd_t c;
		c = rand_cmd(OP_TICK);
		c.home_switch = sw;
		c.current_position = pos;
		return c;
	endfunction

	function automatic seq_cmd_t mk(input logic [1:0] code, input logic [3:0] idx,
			input logic signed [31:0] addr, input logic [15:0] spd, input logic sw,
			input logic signed [31:0] pos);
		seq_cmd_t c;
		c.op = code;
		c.station_index = idx;
		c.station_address = addr;
		c.speed = spd;
		c.home_switch = sw;
		c.current_position = pos;
		return c;
	endfunction

	function automatic logic signed [31:0] below_retract();
		return $urandom_range(0, 1) ? 32'($urandom_range(0, 39)) : {1'b1, 31'($urandom)};
	endfunction

	function automatic logic signed [31:0] past_retract();
		return $urandom_range(0, 1) ? 32'($urandom_range(40, 400)) : {1'b0, 31'($urandom)};
	endfunction

	task automatic push_cmd(input seq_cmd_t c);
		if (c.op == OP_DEFINE && gen_count < DEPTH) begin
			gen_addr[gen_count] = c.station_address;
			gen_count++;
		end
		pending_cmds = {pending_cmds, c};
		queued_items++;
	endtask

	task automatic add_homing();
		bit chained;
		push_cmd(rand_cmd(OP_HOME));
		repeat ($urandom_range(0, 3)) push_cmd(tick_cmd(1'b0, $urandom));
		push_cmd(tick_cmd(1'b1, $urandom));
		// sometimes leave the sequence broken
		if ($urandom_range(0, 9) == 0)
			return;
		repeat ($urandom_range(0, 3)) push_cmd(tick_cmd(1'b0, below_retract()));
		chained = ($urandom_range(0, 2) == 0);
		push_cmd(tick_cmd(chained, past_retract()));
		if (!chained) begin
			repeat ($urandom_range(0, 3)) push_cmd(tick_cmd(1'b0, $urandom));
			push_cmd(tick_cmd(1'b1, $urandom));
		end
		repeat ($urandom_range(0, 2)) push_cmd(tick_cmd(1'($urandom), $urandom));
		if ($urandom_range(0, 3) != 0)
			push_cmd(tick_cmd(1'($urandom), gen_park));
	endtask

	task automatic add_goto();
		seq_cmd_t           c;
		logic signed [31:0] dest;
		c = rand_cmd(OP_GOTO);
		if ($urandom_range(0, 9) != 0)
			c.station_index = 4'($urandom_range(0, gen_count - 1));
		push_cmd(c);
		if (int'(c.station_index) < gen_count) begin
			dest = (c.station_index == 4'd0) ? gen_park : gen_addr[c.station_index];
			repeat ($urandom_range(0, 3)) push_cmd(tick_cmd(1'($urandom), $urandom));
			if ($urandom_range(0, 4) != 0)
				push_cmd(tick_cmd(1'($urandom), dest));
		end
	endtask

	task automatic add_random(input int goal);
		int pick;
		queued_items = 0;
		while (queued_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				add_homing();
			else if (pick < 65)
				add_goto();
			else if (pick < 75)
				push_cmd(rand_cmd(OP_DEFINE));
			else
				push_cmd(rand_cmd(2'($urandom_range(0, 3))));
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// input transfers feed the shadow sequencer
	always @(posedge clk) begin : accept_input
		seq_cmd_t c;
		result_t  r;
		if (cfg_wr_en)
			seq_park = cfg_wr_data;
		if (arst_n && in_valid && !in_stall) begin
			c.op = op;
			c.station_index = station_index;
			c.station_address = station_address;
			c.speed = speed;
			c.home_switch = home_switch;
			c.current_position = current_position;
			r = sequencer_step(c);
			expected_results = {expected_results, r};
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : driver
		seq_cmd_t c;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				op <= c.op;
				station_index <= c.station_index;
				station_address <= c.station_address;
				speed <= c.speed;
				home_switch <= c.home_switch;
				current_position <= c.current_position;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_results.pop_front();
				check_field("machine_state", machine_state, want.machine_state);
				check_field("homing_stage", homing_stage, want.homing_stage);
				check_field("stop_motor", stop_motor, want.stop_motor);
				check_field("load_position_valid", load_position_valid, want.load_position_valid);
				check_field("load_position_value", load_position_value, want.load_position_value);
				check_field("target_valid", target_valid, want.target_valid);
				check_field("target_position", target_position, want.target_position);
				check_field("max_speed", max_speed, want.max_speed);
				check_field("homed_event", homed_event, want.homed_event);
				check_field("reached_event", reached_event, want.reached_event);
				check_field("station_out", station_out, want.station_out);
				check_field("error", error, want.error);
			end
		end
	end

	initial begin : stimulus
		logic signed [31:0] parks [6];
		int                 stall_by_phase [6];
		int                 gap_by_phase [6];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = OP_TICK;
		station_index = '0;
		station_address = '0;
		speed = '0;
		home_switch = 1'b0;
		current_position = '0;
		out_stall = 1'b0;
		seq_mode = MS_NOT_READY;
		seq_stage = HS_SEEK;
		seq_count = 1;
		seq_station = '0;
		seq_dest = '0;
		seq_park = '0;
		gen_count = 1;
		gen_park = '0;
		mismatches = 0;
		queued_items = 0;
		in_taken = 1'b0;
		burst_left = 1;
		gap_left = 0;
		gap_max = 3;
		stall_pct = 30;
		hold_left = 0;
		hold_request = 1'b0;
		parks = '{32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd0, -32'sd1};
		parks[3] = $urandom;
		stall_by_phase = '{30, 0, 20, 70, 40, 10};
		gap_by_phase = '{3, 0, 2, 6, 1, 10};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed: park register still at its reset value
		push_cmd(mk(OP_TICK, 4'd15, 32'sh7fffffff, 16'hffff, 1'b1, 32'sh80000000));
		push_cmd(mk(OP_GOTO, 4'd1, 32'sd0, 16'd100, 1'b0, 32'sd0));
		push_cmd(mk(OP_GOTO, 4'd0, 32'sd0, 16'hffff, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd5));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd0));
		push_cmd(mk(OP_DEFINE, 4'd0, 32'sh7fffffff, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_DEFINE, 4'd15, 32'sh80000000, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_GOTO, 4'd2, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sh80000000));
		push_cmd(mk(OP_HOME, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd1000));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd39));
		// retract and refine complete in one tick
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd40));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_HOME, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, -32'sd5));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sh7fffffff));
		// go to station abandons homing
		push_cmd(mk(OP_GOTO, 4'd1, 32'sd0, 16'd1234, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sh7fffffff));
		push_cmd(mk(OP_HOME, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd0));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b0, 32'sd41));
		push_cmd(mk(OP_TICK, 4'd0, 32'sd0, 16'd0, 1'b1, 32'sd0));
		add_random(100);
		wait_idle();

		for (int p = 1; p < 6; p++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= parks[p];
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			gen_park = parks[p];
			@(posedge clk);
			stall_pct = stall_by_phase[p];
			gap_max = gap_by_phase[p];
			add_random(125);
			// long receiver hold-off while the sender keeps offering
			if (p == 2)
				hold_request = 1'b1;
			wait_idle();
		end

		if (mismatches == 0)
			$display("tb_stepper_homing_station_sequencer: PASS");
		else
			$display("tb_stepper_homing_station_sequencer: FAIL");
		$finish;
	end

endmodule
